### hdl/feh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fire heat update package
// Shared widths, register codes, defaults and small arithmetic helpers.
// ----------------------------------------------------------------------------
package feh_pkg;

   localparam int DEF_GRID_COLS = 20;
   localparam int DEF_GRID_ROWS = 12;

   localparam int HEAT_W     = 8;
   localparam int NOISE_W    = 8;
   localparam int PIX_COL_W  = 5;
   localparam int PIX_ROW_W  = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int LOSS_W     = HEAT_W + 1;

   localparam logic [CSR_IDX_W-1:0] CSR_EMBER_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EMBER_SLOPE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COOL_BASE   = 2'd2;

   localparam logic [HEAT_W-1:0] EMBER_BASE_RST  = 8'd150;
   localparam logic [HEAT_W-1:0] EMBER_SLOPE_RST = 8'd11;
   localparam logic [HEAT_W-1:0] COOL_BASE_RST   = 8'd16;
   localparam logic [HEAT_W-1:0] HEAT_MAX        = 8'd255;

   // noise mod 40 through a reciprocal: floor(v * 205 / 8192) == floor(v / 40)
   localparam logic [15:0] MOD40_RECIP = 16'd205;
   localparam int          MOD40_SHIFT = 13;
   localparam logic [8:0]  EMBER_MOD   = 9'd40;

   typedef struct packed {
      logic [HEAT_W-1:0] target;  // saturated ember target
      logic [LOSS_W-1:0] loss;    // cooling for upper rows
   } feh_calc_type;

   typedef struct packed {
      logic [HEAT_W-1:0] center;
      logic [HEAT_W-1:0] left;
      logic [HEAT_W-1:0] right;
   } feh_taps_type;

   function automatic logic [5:0] noise_mod40(input logic [NOISE_W-1:0] v);
      logic [15:0] prod;
      logic [2:0]  quot;
      logic [8:0]  back;
      logic [7:0]  rem;
      prod = 16'(v) * MOD40_RECIP;
      quot = prod[MOD40_SHIFT+:3];
      back = 9'(quot) * EMBER_MOD;
      rem  = v - back[7:0];
      return rem[5:0];
   endfunction

endpackage

### hdl/feh_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fire heat channels
// Request channel (noise byte) and response channel (updated pixel).
// ----------------------------------------------------------------------------
interface feh_req_if;
   import feh_pkg::*;
   logic               valid;
   logic               ready;
   logic [NOISE_W-1:0] noise;
   modport source (output valid, output noise, input ready);
   modport sink   (input valid, input noise, output ready);
endinterface

interface feh_rsp_if;
   import feh_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [PIX_COL_W-1:0] pixel_col;
   logic [PIX_ROW_W-1:0] pixel_row;
   logic [HEAT_W-1:0]    pixel_heat;
   logic                 frame_end;
   modport source (output valid, output pixel_col, output pixel_row,
                   output pixel_heat, output frame_end, input ready);
   modport sink   (input valid, input pixel_col, input pixel_row,
                   input pixel_heat, input frame_end, output ready);
endinterface

### hdl/feh_heat_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heat grid memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module feh_heat_ram #(
   parameter int DEPTH  = feh_pkg::DEF_GRID_COLS * feh_pkg::DEF_GRID_ROWS,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [feh_pkg::HEAT_W-1:0] rd_data,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [feh_pkg::HEAT_W-1:0] wr_data
);
   import feh_pkg::*;

   logic [HEAT_W-1:0] mem_ff [DEPTH];
   logic [HEAT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/feh_row_line.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row-below line
// Rotating shift line holding the row below; taps give center, right, left.
// ----------------------------------------------------------------------------
module feh_row_line #(
   parameter int GRID_COLS = feh_pkg::DEF_GRID_COLS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       shift_en,
   input  logic [feh_pkg::HEAT_W-1:0] push_data,
   input  logic                       col_first,
   input  logic                       col_last,
   output feh_pkg::feh_taps_type      taps
);
   import feh_pkg::*;

   logic [HEAT_W-1:0] line_ff [GRID_COLS];
   logic [HEAT_W-1:0] line_in [GRID_COLS];
   logic [HEAT_W-1:0] left_ff;
   logic [HEAT_W-1:0] left_in;

   // Slot 0 is always the current column; the freshly stored value enters at the tail.
   always_comb begin
      for (int i = 0; i < GRID_COLS - 1; i++) begin
         line_in[i] = line_ff[i+1];
      end
      line_in[GRID_COLS-1] = push_data;
      left_in = line_ff[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < GRID_COLS; i++) begin
            line_ff[i] <= '0;
         end
         left_ff <= '0;
      end else if (shift_en) begin
         line_ff <= line_in;
         left_ff <= left_in;
      end
   end

   always_comb begin
      taps.center = line_ff[0];
      taps.left   = col_first ? line_ff[0] : left_ff;
      taps.right  = col_last  ? line_ff[0] : line_ff[1];
   end

endmodule

### hdl/feh_ember_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ember and cooling terms
// Works out the saturated ember target and the cooling loss for one pixel.
// ----------------------------------------------------------------------------
module feh_ember_calc #(
   parameter int GRID_COLS = feh_pkg::DEF_GRID_COLS,
   parameter int COL_W     = $clog2(GRID_COLS)
) (
   input  logic [COL_W-1:0]            col,
   input  logic [feh_pkg::NOISE_W-1:0] noise,
   input  logic [feh_pkg::HEAT_W-1:0]  ember_base,
   input  logic [feh_pkg::HEAT_W-1:0]  ember_slope,
   input  logic [feh_pkg::HEAT_W-1:0]  cool_base,
   output feh_pkg::feh_calc_type       calc
);
   import feh_pkg::*;

   localparam int PROD_W = COL_W + HEAT_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam logic [COL_W-1:0] HALF     = COL_W'(GRID_COLS / 2);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(GRID_COLS - 1);

   logic [COL_W-1:0]  edge_dist;
   logic [PROD_W-1:0] slope_term;
   logic [5:0]        ember_noise;
   logic [SUM_W-1:0]  target_sum;

   always_comb begin
      edge_dist   = (col < HALF) ? col : (LAST_COL - col);
      slope_term  = PROD_W'(edge_dist) * PROD_W'(ember_slope);
      ember_noise = noise_mod40(noise);
      target_sum  = SUM_W'(ember_base) + SUM_W'(slope_term) + SUM_W'(ember_noise);
      calc.target = (target_sum > SUM_W'(HEAT_MAX)) ? HEAT_MAX : target_sum[HEAT_W-1:0];
      calc.loss   = LOSS_W'(cool_base) + LOSS_W'(noise[3:0]);
   end

endmodule

### hdl/fire_effect_heat_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fire effect heat update
// Updates one pixel of the heat grid per request, bottom row first.
// ----------------------------------------------------------------------------
// Flow: on accept a request enters the work stage, then the response register.
// Throughput: one request per cycle unless stalled; heat memory reads a pixel at accept and
//    writes it back as the work stage advances, a different address from the next read.
// Reset: registers return to defaults, scan restarts at the bottom-left pixel,
//    and the grid reads as zero until each pixel is first written (first frame).
// ----------------------------------------------------------------------------
module fire_effect_heat_update #(
   parameter int GRID_COLS = feh_pkg::DEF_GRID_COLS,
   parameter int GRID_ROWS = feh_pkg::DEF_GRID_ROWS
) (
   input  logic                          clock,
   input  logic                          reset,
   feh_req_if.sink                       req_chan,
   feh_rsp_if.source                     rsp_chan,
   input  logic                          csr_we,
   input  logic [feh_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [feh_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import feh_pkg::*;

   localparam int DEPTH  = GRID_COLS * GRID_ROWS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int COL_W  = $clog2(GRID_COLS);
   localparam int ROW_W  = $clog2(GRID_ROWS);
   localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(GRID_COLS - 1);
   localparam logic [ROW_W-1:0]  BOTTOM_ROW  = ROW_W'(GRID_ROWS - 1);
   localparam logic [ADDR_W-1:0] BOTTOM_BASE = ADDR_W'((GRID_ROWS - 1) * GRID_COLS);
   localparam logic [ADDR_W-1:0] ROW_UP_STEP = ADDR_W'(2 * GRID_COLS - 1);

   // Configuration registers
   logic [HEAT_W-1:0] ember_base_ff, ember_slope_ff, cool_base_ff;

   // Scan position of the next request
   logic [COL_W-1:0]  col_ff,  col_in;
   logic [ROW_W-1:0]  row_ff,  row_in;
   logic [ADDR_W-1:0] idx_ff,  idx_in;
   logic              fresh_ff, fresh_in;   // first frame after reset

   // Read-modify-write stage
   logic              s1_valid_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic              s1_bottom_ff, s1_first_ff, s1_last_ff, s1_fresh_ff, s1_end_ff;
   feh_calc_type      s1_calc_ff;

   // Response register
   logic                 out_valid_ff;
   logic [PIX_COL_W-1:0] out_col_ff;
   logic [PIX_ROW_W-1:0] out_row_ff;
   logic [HEAT_W-1:0]    out_heat_ff;
   logic                 out_end_ff;

   logic              accept, s1_go, req_ready;
   logic              at_last_col, at_top_row;
   feh_calc_type      calc;
   feh_taps_type      taps;
   logic [HEAT_W-1:0] rd_data, old_heat, new_heat, bottom_heat, upper_heat, avg_heat;
   logic [HEAT_W:0]   bottom_sum;
   logic [HEAT_W+1:0] avg_sum;

   // ---------------------------------------------------------------- control
   // Advance the work stage whenever the response register is free or draining.
   assign s1_go     = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_ready = !reset && (!s1_valid_ff || s1_go);
   assign accept    = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;

   assign at_last_col = (col_ff == LAST_COL);
   assign at_top_row  = (row_ff == '0);

   // ------------------------------------------------------------ config port
   always_ff @(posedge clock) begin
      if (reset) begin
         ember_base_ff  <= EMBER_BASE_RST;
         ember_slope_ff <= EMBER_SLOPE_RST;
         cool_base_ff   <= COOL_BASE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_EMBER_BASE:  ember_base_ff  <= csr_wdata;
            CSR_EMBER_SLOPE: ember_slope_ff <= csr_wdata;
            CSR_COOL_BASE:   cool_base_ff   <= csr_wdata;
            default: ;  // drop writes to unused indexes
         endcase
      end
   end

   // ----------------------------------------------------------- scan counters
   // Walk left to right; at a row end step the address up one row, and at the
   // frame end wrap back to the bottom row. The fresh flag drops after the
   // first full frame, once every pixel has been written.
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      idx_in   = idx_ff;
      fresh_in = fresh_ff;
      if (accept) begin
         if (!at_last_col) begin
            col_in = col_ff + 1'b1;
            idx_in = idx_ff + 1'b1;
         end else begin
            col_in = '0;
            if (at_top_row) begin
               row_in   = BOTTOM_ROW;
               idx_in   = BOTTOM_BASE;
               fresh_in = 1'b0;
            end else begin
               row_in = row_ff - 1'b1;
               idx_in = idx_ff - ROW_UP_STEP;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= BOTTOM_ROW;
         idx_ff   <= BOTTOM_BASE;
         fresh_ff <= 1'b1;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         idx_ff   <= idx_in;
         fresh_ff <= fresh_in;
      end
   end

   // ------------------------------------------------------- accept-side terms
   feh_ember_calc #(
      .GRID_COLS (GRID_COLS),
      .COL_W     (COL_W)
   ) u_calc (
      .col         (col_ff),
      .noise       (req_chan.noise),
      .ember_base  (ember_base_ff),
      .ember_slope (ember_slope_ff),
      .cool_base   (cool_base_ff),
      .calc        (calc)
   );

   // Load the work stage on accept; hold it while the response side stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff   <= idx_ff;
         s1_col_ff    <= col_ff;
         s1_row_ff    <= row_ff;
         s1_bottom_ff <= (row_ff == BOTTOM_ROW);
         s1_first_ff  <= (col_ff == '0);
         s1_last_ff   <= at_last_col;
         s1_fresh_ff  <= fresh_ff;
         s1_end_ff    <= at_top_row && at_last_col;
         s1_calc_ff   <= calc;
      end
   end

   // ------------------------------------------------------- heat memory + line
   feh_heat_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (idx_ff),
      .rd_data (rd_data),
      .wr_en   (s1_go),
      .wr_addr (s1_addr_ff),
      .wr_data (new_heat)
   );

   // The line receives the updated heat on the bottom row and the previous
   // frame's heat on upper rows, so the next row up sees the right values.
   feh_row_line #(
      .GRID_COLS (GRID_COLS)
   ) u_line (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (s1_go),
      .push_data (s1_bottom_ff ? new_heat : old_heat),
      .col_first (s1_first_ff),
      .col_last  (s1_last_ff),
      .taps      (taps)
   );

   // ------------------------------------------------------------ pixel update
   always_comb begin
      old_heat    = s1_fresh_ff ? '0 : rd_data;
      bottom_sum  = (HEAT_W+1)'(old_heat) + (HEAT_W+1)'(s1_calc_ff.target);
      bottom_heat = bottom_sum[HEAT_W:1];
      avg_sum     = (HEAT_W+2)'({taps.center, 1'b0}) + (HEAT_W+2)'(taps.left)
                  + (HEAT_W+2)'(taps.right);
      avg_heat    = avg_sum[HEAT_W+1:2];
      upper_heat  = (LOSS_W'(avg_heat) > s1_calc_ff.loss)
                  ? HEAT_W'(LOSS_W'(avg_heat) - s1_calc_ff.loss) : '0;
      new_heat    = s1_bottom_ff ? bottom_heat : upper_heat;
   end

   // --------------------------------------------------------- response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_go) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         out_col_ff  <= PIX_COL_W'(s1_col_ff);
         out_row_ff  <= PIX_ROW_W'(s1_row_ff);
         out_heat_ff <= new_heat;
         out_end_ff  <= s1_end_ff;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.pixel_col  = out_col_ff;
   assign rsp_chan.pixel_row  = out_row_ff;
   assign rsp_chan.pixel_heat = out_heat_ff;
   assign rsp_chan.frame_end  = out_end_ff;

endmodule

### hdl/feh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fire heat update checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
module feh_checker #(
   parameter int GRID_COLS = feh_pkg::DEF_GRID_COLS
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [feh_pkg::PIX_COL_W-1:0]   pixel_col,
   input logic [feh_pkg::PIX_ROW_W-1:0]   pixel_row,
   input logic [feh_pkg::HEAT_W-1:0]      pixel_heat,
   input logic                            frame_end
);
   import feh_pkg::*;

   // No response is left over from before reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // With the response register empty the block must take a request.
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("request blocked while response side is empty");

   // A stalled response holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pixel_col) && $stable(pixel_row)
      && $stable(pixel_heat) && $stable(frame_end))
      else $error("stalled response changed");

   // The frame ends only on the top-right pixel.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_end |-> pixel_row == '0 && pixel_col == PIX_COL_W'(GRID_COLS - 1))
      else $error("frame end on wrong pixel");

endmodule

bind fire_effect_heat_update feh_checker #(
   .GRID_COLS (GRID_COLS)
) u_feh_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .pixel_col  (rsp_chan.pixel_col),
   .pixel_row  (rsp_chan.pixel_row),
   .pixel_heat (rsp_chan.pixel_heat),
   .frame_end  (rsp_chan.frame_end)
);
